// ===== rtl/gbc_pkg.sv =====
// Package: shared constants and types for the gyro bias calibrator.
package gbc_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int RATE_WIDTH_DEF  = 20;
   localparam int ACCEL_WIDTH_DEF = 16;
   localparam int SUM_WIDTH_DEF   = 36;

   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE  = 2'd1;
   localparam logic [1:0] KIND_CORRECT = 2'd2;
   localparam logic [1:0] KIND_RESET   = 2'd3;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_COLLECT = 3'd1;
   localparam logic [2:0] PH_VALID   = 3'd2;
   localparam logic [2:0] PH_TIMEOUT = 3'd3;
   localparam logic [2:0] PH_BADARG  = 3'd4;

   localparam logic [2:0] CSR_TARGET  = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT = 3'd1;
   localparam logic [2:0] CSR_AMIN    = 3'd2;
   localparam logic [2:0] CSR_AMAX    = 3'd3;
   localparam logic [2:0] CSR_RMAX    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAG,
      ST_DIV,
      ST_DIVSTEP,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/gbc_sqmag.sv =====
// Serial sum of squares of three signed values, one multiplier bit per cycle.
module gbc_sqmag #(
   parameter int W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [W-1:0]  a,
   input  logic signed [W-1:0]  b,
   input  logic signed [W-1:0]  c,
   output logic                 done,
   output logic [2*W+1:0]       sum
);
   localparam int CW = $clog2(W + 1);
   localparam int SW = 2 * W + 2;

   logic [W-1:0]  ma_ff, mb_ff, mc_ff;
   logic [W-1:0]  ma_in, mb_in, mc_in;
   logic [SW-1:0] sa_ff, sb_ff, sc_ff, sa_in, sb_in, sc_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W-1:0]  abs_a, abs_b, abs_c;
   logic [SW-1:0] part;

   assign abs_a = a[W-1] ? W'(-a) : W'(a);
   assign abs_b = b[W-1] ? W'(-b) : W'(b);
   assign abs_c = c[W-1] ? W'(-c) : W'(c);

   assign part = (ma_ff[0] ? sa_ff : '0) + (mb_ff[0] ? sb_ff : '0)
               + (mc_ff[0] ? sc_ff : '0);

   always_comb begin
      ma_in = ma_ff; mb_in = mb_ff; mc_in = mc_ff;
      sa_in = sa_ff; sb_in = sb_ff; sc_in = sc_ff;
      acc_in = acc_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         ma_in = abs_a; mb_in = abs_b; mc_in = abs_c;
         sa_in = SW'(abs_a); sb_in = SW'(abs_b); sc_in = SW'(abs_c);
         acc_in = '0; cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part;
         ma_in = ma_ff >> 1; mb_in = mb_ff >> 1; mc_in = mc_ff >> 1;
         sa_in = sa_ff << 1; sb_in = sb_ff << 1; sc_in = sc_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      ma_ff <= ma_in; mb_ff <= mb_in; mc_ff <= mc_in;
      sa_ff <= sa_in; sb_ff <= sb_in; sc_ff <= sc_in;
      acc_ff <= acc_in;
   end

   assign done = ~busy_ff & ~start;
   assign sum  = acc_ff;
endmodule

// ===== rtl/gyro_bias_calibrator_top.sv =====
// Top level of the gyro bias calibrator.
// Usage: requests enter on req_* (valid/ready); each request yields exactly one
// response on rsp_* (valid/ready). Configuration registers are written through
// csr_we/csr_index/csr_wdata while the block is idle; writes take effect at once.
// Start, reset and correct requests pass through the done state to the response register.
// A sample request runs two serial squared-magnitude units, one multiplier bit
// per cycle. When the target count is met, a restoring divider then forms the
// three bias values, one quotient bit per cycle, one axis after the other,
// before the response register is loaded.
// One request is in flight at a time.
// The response register holds while rsp_ready is low; req_ready stays low until
// the response is taken. Synchronous reset returns to idle, clears the run state
// and loads the register defaults.
module gyro_bias_calibrator_top
   import gbc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int RATE_WIDTH  = RATE_WIDTH_DEF,
   parameter int ACCEL_WIDTH = ACCEL_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic signed [RATE_WIDTH-1:0]  req_rate_x,
   input  logic signed [RATE_WIDTH-1:0]  req_rate_y,
   input  logic signed [RATE_WIDTH-1:0]  req_rate_z,
   input  logic signed [ACCEL_WIDTH-1:0] req_accel_x,
   input  logic signed [ACCEL_WIDTH-1:0] req_accel_y,
   input  logic signed [ACCEL_WIDTH-1:0] req_accel_z,
   input  logic [31:0]                   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_bias_ready,
   output logic signed [RATE_WIDTH-1:0]  rsp_fixed_x,
   output logic signed [RATE_WIDTH-1:0]  rsp_fixed_y,
   output logic signed [RATE_WIDTH-1:0]  rsp_fixed_z,
   output logic [COUNT_WIDTH-1:0]        rsp_accepted_count,
   output logic [COUNT_WIDTH-1:0]        rsp_rejected_count,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);
   localparam int SW  = RATE_WIDTH + COUNT_WIDTH;
   localparam int AQW = 2 * ACCEL_WIDTH + 2;
   localparam int RQW = 2 * RATE_WIDTH + 2;
   localparam int DCW = $clog2(SW + 1);
   localparam logic signed [RATE_WIDTH-1:0] RMAX = {1'b0, {(RATE_WIDTH-1){1'b1}}};
   localparam logic signed [RATE_WIDTH-1:0] RMIN = {1'b1, {(RATE_WIDTH-1){1'b0}}};

   state_type state_ff, state_in;

   logic [15:0] tgt_ff;
   logic [31:0] tmo_ff;
   logic [14:0] amin_ff, amax_ff;
   logic [18:0] rmax_ff;

   logic [2:0]             phase_ff, phase_in;
   logic                   vflag_ff, vflag_in;
   logic [31:0]            stamp_ff, stamp_in;
   logic [COUNT_WIDTH-1:0] good_ff, good_in, bad_ff, bad_in;
   logic signed [SW-1:0]   sx_ff, sy_ff, sz_ff, sx_in, sy_in, sz_in;
   logic signed [RATE_WIDTH-1:0] bx_ff, by_ff, bz_ff, bx_in, by_in, bz_in;

   logic [1:0]             kind_ff;
   logic signed [RATE_WIDTH-1:0] rx_ff, ry_ff, rz_ff;
   logic [31:0]            now_ff;

   logic                   ovalid_ff, ovalid_in;
   logic signed [RATE_WIDTH-1:0] fx_ff, fy_ff, fz_ff, fx_in, fy_in, fz_in;

   // divider
   logic [1:0]             axis_ff, axis_in;
   logic [DCW-1:0]         dcnt_ff, dcnt_in;
   logic [SW-1:0]          dq_ff, dq_in;
   logic [COUNT_WIDTH:0]   drem_ff, drem_in;
   logic                   dneg_ff, dneg_in;

   logic                   mag_start, adone, rdone;
   logic [AQW-1:0]         asq;
   logic [RQW-1:0]         rsq;

   logic                   accept;
   logic [31:0]            elapsed;
   logic [29:0]            amin_sq, amax_sq;
   logic [37:0]            rmax_sq;
   logic                   reject;
   logic signed [SW-1:0]   sel_sum;
   logic [SW-1:0]          abs_sum;
   logic [COUNT_WIDTH:0]   trial;
   logic signed [SW:0]     qs;
   logic signed [RATE_WIDTH-1:0] qsat;

   function automatic logic signed [RATE_WIDTH-1:0] sub_sat(
      input logic signed [RATE_WIDTH-1:0] r, input logic signed [RATE_WIDTH-1:0] b);
      logic signed [RATE_WIDTH:0] d;
      d = {r[RATE_WIDTH-1], r} - {b[RATE_WIDTH-1], b};
      if (d[RATE_WIDTH] != d[RATE_WIDTH-1])
         return d[RATE_WIDTH] ? RMIN : RMAX;
      return d[RATE_WIDTH-1:0];
   endfunction

   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == ST_IDLE) & ~ovalid_ff;
   assign mag_start = (state_ff == ST_IDLE) & accept & (req_kind == KIND_SAMPLE);

   gbc_sqmag #(.W(ACCEL_WIDTH)) u_amag (
      .clock(clock), .reset(reset), .start(mag_start),
      .a(req_accel_x), .b(req_accel_y), .c(req_accel_z), .done(adone), .sum(asq));
   gbc_sqmag #(.W(RATE_WIDTH)) u_rmag (
      .clock(clock), .reset(reset), .start(mag_start),
      .a(req_rate_x), .b(req_rate_y), .c(req_rate_z), .done(rdone), .sum(rsq));

   // bound squares are constant between runs; combinational, 19x19 at most
   assign amin_sq = amin_ff * amin_ff;
   assign amax_sq = amax_ff * amax_ff;
   assign rmax_sq = rmax_ff * rmax_ff;
   assign elapsed = now_ff - stamp_ff;
   assign reject  = (64'(asq) < 64'(amin_sq)) | (64'(asq) > 64'(amax_sq))
                  | (64'(rsq) > 64'(rmax_sq));

   always_comb begin
      case (axis_ff)
         2'd0:    sel_sum = sx_ff;
         2'd1:    sel_sum = sy_ff;
         default: sel_sum = sz_ff;
      endcase
   end
   assign abs_sum = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
   assign trial   = {drem_ff[COUNT_WIDTH-1:0], dq_ff[SW-1]};
   assign qs      = dneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
   assign qsat    = (qs > $signed((SW+1)'(RMAX))) ? RMAX :
                    (qs < $signed({{(SW-RATE_WIDTH+1){1'b1}}, RMIN})) ? RMIN :
                    qs[RATE_WIDTH-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = (req_kind == KIND_SAMPLE) ? ST_MAG : ST_DONE;
         ST_MAG:    if (adone & rdone) state_in = ST_DIV;
         ST_DIV:    state_in = (axis_ff == 2'd3) ? ST_DONE : ST_DIVSTEP;
         ST_DIVSTEP: if (dcnt_ff == '0) state_in = ST_DIV;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in = phase_ff; vflag_in = vflag_ff; stamp_in = stamp_ff;
      good_in = good_ff; bad_in = bad_ff;
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      fx_in = fx_ff; fy_in = fy_ff; fz_in = fz_ff;
      ovalid_in = ovalid_ff & ~rsp_ready;
      axis_in = axis_ff; dcnt_in = dcnt_ff; dq_in = dq_ff;
      drem_in = drem_ff; dneg_in = dneg_ff;
      case (state_ff)
         ST_IDLE: axis_in = 2'd3;
         ST_MAG: begin
            if (adone & rdone) begin
               axis_in = 2'd3;
               if (phase_ff != PH_COLLECT) begin
               end else if (tgt_ff == '0) begin
                  phase_in = PH_BADARG; vflag_in = 1'b0;
               end else if (elapsed >= tmo_ff) begin
                  phase_in = PH_TIMEOUT; vflag_in = 1'b0;
               end else if (reject) begin
                  if (bad_ff != '1) bad_in = bad_ff + 1'b1;
               end else begin
                  sx_in = sx_ff + SW'(rx_ff);
                  sy_in = sy_ff + SW'(ry_ff);
                  sz_in = sz_ff + SW'(rz_ff);
                  if (good_ff != '1) good_in = good_ff + 1'b1;
                  if (32'((good_ff != '1) ? good_ff + 1'b1 : good_ff) >= 32'(tgt_ff)) begin
                     axis_in = 2'd0;
                     vflag_in = 1'b1; phase_in = PH_VALID;
                  end
               end
            end
         end
         ST_DIV: begin
            if (axis_ff != 2'd3) begin
               dq_in = abs_sum; dneg_in = sel_sum[SW-1];
               drem_in = '0; dcnt_in = DCW'(SW);
            end
         end
         ST_DIVSTEP: begin
            if (dcnt_ff != '0) begin
               dcnt_in = dcnt_ff - 1'b1;
               if (trial >= {1'b0, good_ff}) begin
                  drem_in = trial - {1'b0, good_ff};
                  dq_in = {dq_ff[SW-2:0], 1'b1};
               end else begin
                  drem_in = trial;
                  dq_in = {dq_ff[SW-2:0], 1'b0};
               end
            end else begin
               case (axis_ff)
                  2'd0:    bx_in = qsat;
                  2'd1:    by_in = qsat;
                  default: bz_in = qsat;
               endcase
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_DONE: begin
            ovalid_in = 1'b1;
            fx_in = '0; fy_in = '0; fz_in = '0;
            case (kind_ff)
               KIND_START: begin
                  vflag_in = 1'b0; good_in = '0; bad_in = '0;
                  sx_in = '0; sy_in = '0; sz_in = '0;
                  bx_in = '0; by_in = '0; bz_in = '0;
                  stamp_in = now_ff; phase_in = PH_COLLECT;
               end
               KIND_CORRECT: begin
                  if (vflag_ff) begin
                     fx_in = sub_sat(rx_ff, bx_ff);
                     fy_in = sub_sat(ry_ff, by_ff);
                     fz_in = sub_sat(rz_ff, bz_ff);
                  end else begin
                     fx_in = rx_ff; fy_in = ry_ff; fz_in = rz_ff;
                  end
               end
               KIND_RESET: begin
                  phase_in = PH_IDLE; vflag_in = 1'b0; stamp_in = '0;
                  good_in = '0; bad_in = '0;
                  sx_in = '0; sy_in = '0; sz_in = '0;
                  bx_in = '0; by_in = '0; bz_in = '0;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tgt_ff <= 16'd1024; tmo_ff <= 32'd5000;
         amin_ff <= 15'd3686; amax_ff <= 15'd4506; rmax_ff <= 19'd2560;
         phase_ff <= PH_IDLE; vflag_ff <= 1'b0; stamp_ff <= '0;
         good_ff <= '0; bad_ff <= '0;
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0;
         bx_ff <= '0; by_ff <= '0; bz_ff <= '0;
         ovalid_ff <= 1'b0; axis_ff <= 2'd3; dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET:  tgt_ff  <= csr_wdata[15:0];
               CSR_TIMEOUT: tmo_ff  <= csr_wdata;
               CSR_AMIN:    amin_ff <= csr_wdata[14:0];
               CSR_AMAX:    amax_ff <= csr_wdata[14:0];
               CSR_RMAX:    rmax_ff <= csr_wdata[18:0];
               default: ;
            endcase
         end
         phase_ff <= phase_in; vflag_ff <= vflag_in; stamp_ff <= stamp_in;
         good_ff <= good_in; bad_ff <= bad_in;
         sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in;
         bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
         ovalid_ff <= ovalid_in; axis_ff <= axis_in; dcnt_ff <= dcnt_in;
      end
      dq_ff <= dq_in; drem_ff <= drem_in; dneg_ff <= dneg_in;
      fx_ff <= fx_in; fy_ff <= fy_in; fz_ff <= fz_in;
      if (accept) begin
         kind_ff <= req_kind;
         rx_ff <= req_rate_x; ry_ff <= req_rate_y; rz_ff <= req_rate_z;
         now_ff <= req_now_ms;
      end
   end

   assign rsp_valid          = ovalid_ff;
   assign rsp_status         = phase_ff;
   assign rsp_bias_ready     = vflag_ff;
   assign rsp_fixed_x        = fx_ff;
   assign rsp_fixed_y        = fy_ff;
   assign rsp_fixed_z        = fz_ff;
   assign rsp_accepted_count = good_ff;
   assign rsp_rejected_count = bad_ff;
endmodule
